### rtl/jtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP master package
// Shared types, codes and constants for the TAP master block.
// ----------------------------------------------------------------------------
package jtm_pkg;

  // Default sizes handed to the top level parameters
  localparam int WORD_BITS_DEF       = 32;
  localparam int IDLE_COUNT_BITS_DEF = 16;

  // Configuration port
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int REG_IDX_BIT = 2;

  // Register reset values and limits
  localparam logic [5:0] IR_LENGTH_RST     = 6'd10;
  localparam logic [3:0] RESET_CLOCKS_RST  = 4'd6;
  localparam logic [3:0] RESET_CLOCKS_MIN  = 4'd5;

  // TCK counts for the fixed TMS walks
  localparam int CLK_IR_ENTRY = 4;
  localparam int CLK_DR_ENTRY = 3;
  localparam int CLK_EXIT     = 2;

  // Register index on the configuration port
  typedef enum logic {
    REG_IR_LENGTH    = 1'b0,
    REG_RESET_CLOCKS = 1'b1
  } reg_idx_t;

  // Command codes of an input transaction
  typedef enum logic [2:0] {
    CMD_TAP_RESET  = 3'd0,
    CMD_IR_SHIFT   = 3'd1,
    CMD_DR_SEGMENT = 3'd2,
    CMD_RUN_IDLE   = 3'd3,
    CMD_TICK       = 3'd4
  } cmd_t;

  // Kind of the pending segment
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_RESET = 3'd1,
    KIND_IR    = 3'd2,
    KIND_DR    = 3'd3,
    KIND_IDLE  = 3'd4
  } kind_t;

  // Phase within an IR or DR segment
  typedef enum logic [1:0] {
    PH_ENTRY = 2'd0,
    PH_BITS  = 2'd1,
    PH_EXIT  = 2'd2
  } phase_t;

  // Configuration register contents
  typedef struct packed {
    logic [5:0] ir_length;
    logic [3:0] reset_clocks;
  } cfg_t;

  // Bit count of a shift: zero counts as one, above the word size as the word size
  function automatic logic [6:0] clamp_bits(input logic [5:0] v, input int unsigned lim);
    logic [6:0] lim_w;
    lim_w = 7'(lim);
    if (v == 6'd0) begin
      return 7'd1;
    end
    if ({1'b0, v} > lim_w) begin
      return lim_w;
    end
    return {1'b0, v};
  endfunction

endpackage

### rtl/jtm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP master channel interfaces
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface jtm_cmd_if #(
  parameter int WORD_BITS       = 32,
  parameter int IDLE_COUNT_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic [2:0]                 command;
  logic [WORD_BITS-1:0]       data;
  logic [5:0]                 bit_count;
  logic                       enter_shift;
  logic                       exit_shift;
  logic [IDLE_COUNT_BITS-1:0] idle_count;
  logic                       tdo_in;

  modport source (
    output valid, command, data, bit_count, enter_shift, exit_shift, idle_count, tdo_in,
    input  ready
  );
  modport sink (
    input  valid, command, data, bit_count, enter_shift, exit_shift, idle_count, tdo_in,
    output ready
  );
endinterface

interface jtm_res_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 tck_pulse;
  logic                 tms_out;
  logic                 tdi_out;
  logic                 segment_end;
  logic [WORD_BITS-1:0] captured_word;
  logic                 rejected;

  modport source (
    output valid, tck_pulse, tms_out, tdi_out, segment_end, captured_word, rejected,
    input  ready
  );
  modport sink (
    input  valid, tck_pulse, tms_out, tdi_out, segment_end, captured_word, rejected,
    output ready
  );
endinterface

### rtl/jtm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP master configuration registers
// APB-style register file holding the IR length and TAP reset length.
// ----------------------------------------------------------------------------
module jtm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jtm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [jtm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [jtm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output jtm_pkg::cfg_t                   cfg
);
  import jtm_pkg::*;

  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[REG_IDX_BIT]);

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ir_length    <= IR_LENGTH_RST;
      cfg.reset_clocks <= RESET_CLOCKS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_IR_LENGTH:    cfg.ir_length    <= pwdata[5:0];
        REG_RESET_CLOCKS: cfg.reset_clocks <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_sel)
      REG_IR_LENGTH:    prdata = {{(APB_DATA_W-6){1'b0}}, cfg.ir_length};
      REG_RESET_CLOCKS: prdata = {{(APB_DATA_W-4){1'b0}}, cfg.reset_clocks};
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/jtm_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP master input register
// Pipeline register between the command channel and the step logic.
// ----------------------------------------------------------------------------
module jtm_in_stage (
  input  logic      clk,
  input  logic      rst,
  jtm_cmd_if.sink   cmd,
  jtm_cmd_if.source item
);

  // Take a new transaction whenever the register is empty or draining
  assign cmd.ready = !item.valid || item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (cmd.ready) begin
      item.valid <= cmd.valid;
    end
  end

  // Hold the payload of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.command     <= cmd.command;
      item.data        <= cmd.data;
      item.bit_count   <= cmd.bit_count;
      item.enter_shift <= cmd.enter_shift;
      item.exit_shift  <= cmd.exit_shift;
      item.idle_count  <= cmd.idle_count;
      item.tdo_in      <= cmd.tdo_in;
    end
  end

endmodule

### rtl/jtm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP master step engine
// Segment state, one TCK step per tick transaction, and the result register.
// ----------------------------------------------------------------------------
module jtm_engine #(
  parameter int WORD_BITS       = jtm_pkg::WORD_BITS_DEF,
  parameter int IDLE_COUNT_BITS = jtm_pkg::IDLE_COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  jtm_pkg::cfg_t cfg,
  jtm_cmd_if.sink       item,
  jtm_res_if.source     res
);
  import jtm_pkg::*;

  localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int CNT_W = $clog2(WORD_BITS + 1);

  kind_t                      kind, kind_next;
  phase_t                     phase, phase_next;
  logic [WORD_BITS-1:0]       send_word, send_word_next;
  logic [WORD_BITS-1:0]       capture_word, capture_word_next;
  logic [IDX_W-1:0]           bit_pos, bit_pos_next;
  logic [CNT_W-1:0]           bit_total, bit_total_next;
  logic [IDLE_COUNT_BITS-1:0] clocks_left, clocks_left_next;
  logic                       exit_flag, exit_flag_next;

  logic                       advance;
  logic                       take;
  logic                       pending;
  logic [CNT_W-1:0]           pos_inc;
  logic                       last_bit;
  logic                       goes_exit;
  logic [WORD_BITS-1:0]       cap_bit;
  logic [3:0]                 reset_len;
  logic [IDLE_COUNT_BITS-1:0] left_dec;

  logic                       tck_c;
  logic                       tms_c;
  logic                       tdi_c;
  logic                       end_c;
  logic                       rej_c;
  logic [WORD_BITS-1:0]       word_c;

  // Handshake: step a transaction whenever the result register can take it
  assign advance    = !res.valid || res.ready;
  assign item.ready = advance;
  assign take       = item.valid && advance;

  // Shared step terms
  assign pending   = (kind != KIND_NONE);
  assign pos_inc   = CNT_W'(bit_pos) + CNT_W'(1);
  assign last_bit  = (pos_inc >= bit_total);
  assign goes_exit = (kind == KIND_IR) || exit_flag;
  assign cap_bit   = capture_word | ({{(WORD_BITS-1){1'b0}}, item.tdo_in} << bit_pos);
  assign reset_len = (cfg.reset_clocks < RESET_CLOCKS_MIN) ? RESET_CLOCKS_MIN
                                                           : cfg.reset_clocks;
  assign left_dec  = clocks_left - IDLE_COUNT_BITS'(1);

  // Result of the current transaction
  always_comb begin
    tck_c  = 1'b0;
    tms_c  = 1'b0;
    tdi_c  = 1'b0;
    end_c  = 1'b0;
    rej_c  = 1'b0;
    word_c = '0;
    case (cmd_t'(item.command))
      CMD_TAP_RESET, CMD_IR_SHIFT, CMD_DR_SEGMENT, CMD_RUN_IDLE: begin
        rej_c = pending;
      end
      CMD_TICK: begin
        if (pending) begin
          tck_c = 1'b1;
          if (kind == KIND_RESET || kind == KIND_IDLE) begin
            tms_c = (kind == KIND_RESET);
            end_c = (clocks_left == IDLE_COUNT_BITS'(1));
          end else begin
            case (phase)
              PH_ENTRY: begin
                if (kind == KIND_IR) begin
                  tms_c = (clocks_left > IDLE_COUNT_BITS'(CLK_EXIT));
                end else begin
                  tms_c = (clocks_left == IDLE_COUNT_BITS'(CLK_DR_ENTRY));
                end
              end
              PH_BITS: begin
                tdi_c = send_word[bit_pos];
                tms_c = last_bit && goes_exit;
                end_c = last_bit && !goes_exit;
                if (end_c) begin
                  word_c = cap_bit;
                end
              end
              PH_EXIT: begin
                tms_c = (clocks_left == IDLE_COUNT_BITS'(CLK_EXIT));
                end_c = (clocks_left == IDLE_COUNT_BITS'(1));
                if (end_c && kind == KIND_DR) begin
                  word_c = capture_word;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // Next segment state
  always_comb begin
    kind_next         = kind;
    phase_next        = phase;
    send_word_next    = send_word;
    capture_word_next = capture_word;
    bit_pos_next      = bit_pos;
    bit_total_next    = bit_total;
    clocks_left_next  = clocks_left;
    exit_flag_next    = exit_flag;
    case (cmd_t'(item.command))
      CMD_TAP_RESET, CMD_IR_SHIFT, CMD_DR_SEGMENT, CMD_RUN_IDLE: begin
        if (!pending) begin
          capture_word_next = '0;
          bit_pos_next      = '0;
          phase_next        = PH_ENTRY;
          exit_flag_next    = 1'b0;
          case (cmd_t'(item.command))
            CMD_TAP_RESET: begin
              clocks_left_next = IDLE_COUNT_BITS'(reset_len);
              kind_next        = KIND_RESET;
            end
            CMD_IR_SHIFT: begin
              send_word_next   = item.data;
              bit_total_next   = CNT_W'(clamp_bits(cfg.ir_length, WORD_BITS));
              clocks_left_next = IDLE_COUNT_BITS'(CLK_IR_ENTRY);
              kind_next        = KIND_IR;
            end
            CMD_DR_SEGMENT: begin
              send_word_next   = item.data;
              bit_total_next   = CNT_W'(clamp_bits(item.bit_count, WORD_BITS));
              exit_flag_next   = item.exit_shift;
              if (item.enter_shift) begin
                clocks_left_next = IDLE_COUNT_BITS'(CLK_DR_ENTRY);
              end else begin
                phase_next       = PH_BITS;
                clocks_left_next = '0;
              end
              kind_next = KIND_DR;
            end
            default: begin
              clocks_left_next = item.idle_count;
              kind_next = (item.idle_count != '0) ? KIND_IDLE : KIND_NONE;
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (pending) begin
          if (kind == KIND_RESET || kind == KIND_IDLE) begin
            clocks_left_next = left_dec;
          end else begin
            case (phase)
              PH_ENTRY: begin
                clocks_left_next = left_dec;
                if (left_dec == '0) begin
                  phase_next   = PH_BITS;
                  bit_pos_next = '0;
                end
              end
              PH_BITS: begin
                bit_pos_next = bit_pos + IDX_W'(1);
                if (kind == KIND_DR) begin
                  capture_word_next = cap_bit;
                end
                if (last_bit && goes_exit) begin
                  phase_next       = PH_EXIT;
                  clocks_left_next = IDLE_COUNT_BITS'(CLK_EXIT);
                end
              end
              PH_EXIT: begin
                clocks_left_next = left_dec;
              end
              default: ;
            endcase
          end
          // Drop the segment on its final cycle
          if (end_c) begin
            kind_next        = KIND_NONE;
            phase_next       = PH_ENTRY;
            clocks_left_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Segment control state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind        <= KIND_NONE;
      phase       <= PH_ENTRY;
      clocks_left <= '0;
      exit_flag   <= 1'b0;
    end else if (take) begin
      kind        <= kind_next;
      phase       <= phase_next;
      clocks_left <= clocks_left_next;
      exit_flag   <= exit_flag_next;
    end
  end

  // Segment data
  always_ff @(posedge clk) begin
    if (take) begin
      send_word    <= send_word_next;
      capture_word <= capture_word_next;
      bit_pos      <= bit_pos_next;
      bit_total    <= bit_total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.tck_pulse     <= tck_c;
      res.tms_out       <= tms_c;
      res.tdi_out       <= tdi_c;
      res.segment_end   <= end_c;
      res.captured_word <= word_c;
      res.rejected      <= rej_c;
    end
  end

endmodule

### rtl/jtag_tap_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP master
// Drives TAP reset, IR shift, DR segments and run-idle one TCK per tick.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries command transactions. Codes 0 to 3 load a segment (TAP
//   reset, IR shift, DR segment, run idle); code 4 is a TCK tick that
//   carries the TDO sampled before the rising TCK edge.
//   res returns exactly one result transaction per command transaction:
//   tck_pulse, tms_out and tdi_out for that tick, segment_end on the last
//   cycle of the segment and captured_word (DR TDO bits, LSB first) there.
//   A load while a segment is pending returns rejected and changes nothing.
//   The path is registered: an input register, then the step logic
//   into the result register. One transaction is taken every clock cycle
//   while res is not stalled; the segment state is registered and loops
//   back through the step logic. When res is stalled the result register
//   holds, and one more transaction waits in the input register before
//   cmd.ready drops. Reset drops any pending segment and loads ir_length 10
//   and reset_clocks 6; the APB registers at byte 0 and 4 are written only
//   while the block is idle, a rule for the user the block does not enforce.
// ----------------------------------------------------------------------------
module jtag_tap_master #(
  parameter int WORD_BITS       = jtm_pkg::WORD_BITS_DEF,
  parameter int IDLE_COUNT_BITS = jtm_pkg::IDLE_COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jtm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [jtm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [jtm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  jtm_cmd_if.sink                         cmd,
  jtm_res_if.source                       res
);
  import jtm_pkg::*;

  cfg_t cfg;

  jtm_cmd_if #(
    .WORD_BITS       (WORD_BITS),
    .IDLE_COUNT_BITS (IDLE_COUNT_BITS)
  ) item_q ();

  // Configuration registers
  jtm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  jtm_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .item (item_q.source)
  );

  // Step logic and result register
  jtm_engine #(
    .WORD_BITS       (WORD_BITS),
    .IDLE_COUNT_BITS (IDLE_COUNT_BITS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item_q.sink),
    .res  (res)
  );

`ifndef SYNTHESIS
  // No step while the result register is stalled
  assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !item_q.ready)
    else $error("step logic advanced while result stalled");

  // TMS and TDI drive only on a TCK cycle
  assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.tms_out || res.tdi_out || res.segment_end) |-> res.tck_pulse)
    else $error("pin levels without a TCK cycle");

  // A captured word appears only at the end of a segment
  assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.captured_word != '0) |-> res.segment_end)
    else $error("captured word outside segment end");

  // A rejected load never produces a TCK cycle
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.rejected |-> !res.tck_pulse)
    else $error("rejected transaction produced TCK");
`endif

endmodule
